// ===== hw/rtl/msd_pkg.sv =====
// ----------------------------------------------------------------------------
// msd_pkg
// Shared types and constants of the motion segment detector: register map,
// event codes, the queued frame record and the configuration bundle.
// ----------------------------------------------------------------------------
package msd_pkg;

  // register map
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MOVE_TH   = 3'd0,
    REG_STILL_TH  = 3'd1,
    REG_SETTLE    = 3'd2,
    REG_TAG_WIN   = 3'd3,
    REG_DECIM     = 3'd4,
    REG_MIN_FRM   = 3'd5
  } reg_idx_t;
  localparam int CFG_DATA_W = 24;

  // register reset values
  localparam logic [14:0] MOVE_TH_RST  = 15'd38;
  localparam logic [14:0] STILL_TH_RST = 15'd13;
  localparam logic [23:0] SETTLE_RST   = 24'd600000;
  localparam logic [23:0] TAG_WIN_RST  = 24'd300000;
  localparam logic [7:0]  DECIM_RST    = 8'd10;
  localparam logic [23:0] MIN_FRM_RST  = 24'd40;

  // frame time clamp
  localparam int          DT_W          = 17;
  localparam logic [23:0] DT_MAX_US     = 24'd100000;
  localparam logic [DT_W-1:0] DT_DEFAULT_US = 17'd2000;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // stream widths
  localparam int IN_DATA_W   = 56;
  localparam int OUT_DATA_W  = 104;
  localparam int OUT_USER_W  = 4;

  typedef enum logic [2:0] {
    EV_IDLE      = 3'd0,
    EV_STARTED   = 3'd1,
    EV_RECORDING = 3'd2,
    EV_SAVED     = 3'd3,
    EV_TOO_SHORT = 3'd4,
    EV_EMPTY     = 3'd5
  } event_t;

  typedef struct packed {
    logic [14:0] move_th;
    logic [14:0] still_th;
    logic [23:0] settle_us;
    logic [23:0] tag_win_us;
    logic [7:0]  decim;
    logic [23:0] min_frames;
  } cfg_t;

  // one closed frame, as handed from front to back
  typedef struct packed {
    logic [14:0]     peak;
    logic [DT_W-1:0] dt;
    logic [15:0]     buttons;
  } frame_t;

endpackage

// ===== hw/rtl/msd_front.sv =====
// ----------------------------------------------------------------------------
// msd_front
// Takes joint beats, keeps the running peak magnitude of the frame and, on
// the last joint, pushes the closed frame (peak, clamped dt, buttons).
// ----------------------------------------------------------------------------
module msd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [15:0]     joint_speed,
  input  logic            last_joint,
  input  logic [23:0]     elapsed_us,
  input  logic [15:0]     buttons,
  input  logic            q_full,
  output logic            q_push,
  output msd_pkg::frame_t q_data
);
  import msd_pkg::*;

  logic [14:0]     peak_r, peak_nxt;
  logic [14:0]     mag;
  logic [15:0]     neg;
  logic [14:0]     peak_cand;
  logic            dt_ok;
  logic            accept;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // absolute value, most negative code saturates
  always_comb begin
    neg = 16'(~joint_speed + 16'd1);
    if (joint_speed == 16'h8000) begin
      mag = 15'h7FFF;
    end else if (joint_speed[15]) begin
      mag = neg[14:0];
    end else begin
      mag = joint_speed[14:0];
    end
  end

  assign peak_cand = (mag > peak_r) ? mag : peak_r;

  // unknown or wild frame time falls back to the default
  assign dt_ok = (elapsed_us != 24'd0) && (elapsed_us <= DT_MAX_US);

  always_comb begin
    q_data.peak    = peak_cand;
    q_data.dt      = dt_ok ? elapsed_us[DT_W-1:0] : DT_DEFAULT_US;
    q_data.buttons = buttons;
  end

  assign q_push = accept && last_joint;

  // running peak, cleared when the frame closes
  always_comb begin
    peak_nxt = peak_r;
    if (accept) begin
      peak_nxt = last_joint ? 15'd0 : peak_cand;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= 15'd0;
    end else begin
      peak_r <= peak_nxt;
    end
  end

endmodule

// ===== hw/rtl/msd_fifo.sv =====
// ----------------------------------------------------------------------------
// msd_fifo
// Short frame queue between front and back so each side stalls on its own.
// ----------------------------------------------------------------------------
module msd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  msd_pkg::frame_t push_data,
  input  logic            pop,
  output msd_pkg::frame_t pop_data,
  output logic            full,
  output logic            empty
);
  import msd_pkg::*;

  frame_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                do_push, do_pop;

  assign full     = (count_r == QCNT_W'(QDEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  // pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/msd_back.sv =====
// ----------------------------------------------------------------------------
// msd_back
// Segment tracker: pops closed frames, runs the idle/moving hysteresis,
// the tag window, decimated capture and quiet time, and holds the result beat.
// ----------------------------------------------------------------------------
module msd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  msd_pkg::cfg_t   cfg,
  input  logic            q_empty,
  input  msd_pkg::frame_t q_data,
  output logic            q_pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output msd_pkg::event_t event_res,
  output logic            capture_frame,
  output logic [23:0]     frame_count,
  output logic [15:0]     button_mask,
  output logic [15:0]     segment_number,
  output logic [31:0]     segment_time_us,
  output logic [14:0]     frame_max_speed
);
  import msd_pkg::*;

  // segment state
  logic        moving_r, moving_nxt;
  logic [23:0] still_r, still_nxt;
  logic [31:0] segt_r, segt_nxt;
  logic [23:0] tagt_r, tagt_nxt;
  logic [15:0] mask_r, mask_nxt;
  logic [7:0]  dec_r, dec_nxt;
  logic [23:0] capf_r, capf_nxt;
  logic [15:0] saved_r, saved_nxt;

  // result beat
  logic        ov_r, ov_nxt;
  event_t      ev_r, ev_nxt;
  logic        cap_r, cap_nxt;
  logic [23:0] cnt_r, cnt_nxt;
  logic [14:0] pk_r, pk_nxt;

  logic [32:0] segt_sum;
  logic [24:0] tagt_sum;
  logic [24:0] still_sum;
  logic [7:0]  dec_inc;
  logic [23:0] capf_inc;
  logic        seg_end;

  assign q_pop = !q_empty && (!ov_r || out_tready);

  assign segt_sum  = {1'b0, segt_r} + 33'(q_data.dt);
  assign tagt_sum  = {1'b0, tagt_r} + 25'(q_data.dt);
  assign still_sum = {1'b0, still_r} + 25'(q_data.dt);
  assign dec_inc   = (dec_r == 8'hFF) ? dec_r : dec_r + 8'd1;
  assign capf_inc  = (capf_r == 24'hFFFFFF) ? capf_r : capf_r + 24'd1;

  // frame update
  always_comb begin
    moving_nxt = moving_r;
    still_nxt  = still_r;
    segt_nxt   = segt_r;
    tagt_nxt   = tagt_r;
    mask_nxt   = mask_r;
    dec_nxt    = dec_r;
    capf_nxt   = capf_r;
    saved_nxt  = saved_r;
    ev_nxt     = ev_r;
    cap_nxt    = cap_r;
    cnt_nxt    = cnt_r;
    pk_nxt     = pk_r;
    seg_end    = 1'b0;
    if (q_pop) begin
      pk_nxt  = q_data.peak;
      cap_nxt = 1'b0;
      if (!moving_r) begin
        ev_nxt  = EV_IDLE;
        cnt_nxt = capf_r;
        if (q_data.peak > cfg.move_th) begin
          moving_nxt = 1'b1;
          dec_nxt    = 8'd0;
          mask_nxt   = 16'd0;
          tagt_nxt   = 24'd0;
          segt_nxt   = 32'd0;
          still_nxt  = 24'd0;
          capf_nxt   = 24'd0;
          cnt_nxt    = 24'd0;
          ev_nxt     = EV_STARTED;
        end
      end else begin
        ev_nxt   = EV_RECORDING;
        segt_nxt = segt_sum[32] ? 32'hFFFFFFFF : segt_sum[31:0];
        // button collection inside the tag window
        if (tagt_r < cfg.tag_win_us) begin
          mask_nxt = mask_r | q_data.buttons;
          tagt_nxt = tagt_sum[24] ? 24'hFFFFFF : tagt_sum[23:0];
        end
        // decimated capture
        dec_nxt = dec_inc;
        if (dec_inc >= cfg.decim) begin
          dec_nxt  = 8'd0;
          capf_nxt = capf_inc;
          cap_nxt  = 1'b1;
        end
        cnt_nxt = capf_nxt;
        // quiet time and segment end
        if (q_data.peak < cfg.still_th) begin
          still_nxt = still_sum[24] ? 24'hFFFFFF : still_sum[23:0];
          if (still_nxt >= cfg.settle_us) begin
            seg_end    = 1'b1;
            moving_nxt = 1'b0;
            still_nxt  = 24'd0;
            if (cnt_nxt == 24'd0) begin
              ev_nxt = EV_EMPTY;
            end else if (cnt_nxt < cfg.min_frames) begin
              ev_nxt = EV_TOO_SHORT;
            end else begin
              ev_nxt = EV_SAVED;
              if (saved_r != 16'hFFFF) begin
                saved_nxt = saved_r + 16'd1;
              end
            end
            capf_nxt = 24'd0;
          end
        end else begin
          still_nxt = 24'd0;
        end
      end
    end
  end

  // result beat valid
  always_comb begin
    ov_nxt = ov_r;
    if (q_pop) begin
      ov_nxt = 1'b1;
    end else if (out_tready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      moving_r <= 1'b0;
      still_r  <= 24'd0;
      segt_r   <= 32'd0;
      tagt_r   <= 24'd0;
      mask_r   <= 16'd0;
      dec_r    <= 8'd0;
      capf_r   <= 24'd0;
      saved_r  <= 16'd0;
      ov_r     <= 1'b0;
    end else begin
      moving_r <= moving_nxt;
      still_r  <= still_nxt;
      segt_r   <= segt_nxt;
      tagt_r   <= tagt_nxt;
      mask_r   <= mask_nxt;
      dec_r    <= dec_nxt;
      capf_r   <= capf_nxt;
      saved_r  <= saved_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_r  <= ev_nxt;
    cap_r <= cap_nxt;
    cnt_r <= cnt_nxt;
    pk_r  <= pk_nxt;
  end

  // state only moves with a loaded beat, so the state fields show directly
  assign out_tvalid      = ov_r;
  assign event_res       = ev_r;
  assign capture_frame   = cap_r;
  assign frame_count     = cnt_r;
  assign button_mask     = mask_r;
  assign segment_number  = saved_r;
  assign segment_time_us = segt_r;
  assign frame_max_speed = pk_r;

`ifndef NO_ASSERTIONS
  a_end_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    seg_end |=> !moving_r)
    else $error("segment end did not return to idle");

  a_capture_only_moving: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && cap_r) |-> (ev_r != EV_IDLE && ev_r != EV_STARTED))
    else $error("capture flagged outside a segment");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && ev_r == EV_EMPTY) |-> (cnt_r == 24'd0))
    else $error("empty segment with captured frames");

  a_saved_count: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && ev_nxt == EV_SAVED) |-> (cnt_nxt >= cfg.min_frames && cnt_nxt != 24'd0))
    else $error("segment saved below minimum frame count");
`endif

endmodule

// ===== hw/rtl/motion_segment_detector.sv =====
// ----------------------------------------------------------------------------
// motion_segment_detector
// Hysteresis motion detector over a stream of joint speed samples.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per joint; in_tlast marks the frame's final joint, whose
//           beat also carries elapsed time and the button word.
//   out_* : one result beat per frame, emitted for each in_tlast beat only.
//   cfg_* : register writes (index 0..5), always ready; write only while idle.
// Throughput: one input beat per cycle while the frame queue is not full, including last joints.
// Result path: a frame's last-joint beat is written into the frame queue, and the
//   back then pops it and loads the result beat once that beat is free or taken.
// Stall: the result beat holds while out_tready is low; the four-entry frame
//   queue keeps taking frames, and in_tready drops only once it is full.
// Reset: rst_n low clears peak, segment state, queue and the result beat's valid and
//   restores the register defaults; no input is refused after reset.
// ----------------------------------------------------------------------------
module motion_segment_detector (
  input  logic                               clk,
  input  logic                               rst_n,
  // joint_speed[15:0], elapsed_us[39:16], buttons[55:40]
  input  logic [msd_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                               in_tlast,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // frame_count[23:0], button_mask[39:24], segment_number[55:40],
  // segment_time_us[87:56], frame_max_speed[102:88], zero pad[103]
  output logic [msd_pkg::OUT_DATA_W-1:0]     out_tdata,
  // event_res[2:0], capture_frame[3]
  output logic [msd_pkg::OUT_USER_W-1:0]     out_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [msd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [msd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import msd_pkg::*;

  cfg_t        cfg_r, cfg_nxt;
  logic        q_push, q_pop, q_full, q_empty;
  frame_t      q_in, q_out;
  event_t      ev;
  logic        cap;
  logic [23:0] cnt;
  logic [15:0] mask;
  logic [15:0] segn;
  logic [31:0] segt;
  logic [14:0] pk;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_MOVE_TH:  cfg_nxt.move_th    = cfg_data[14:0];
        REG_STILL_TH: cfg_nxt.still_th   = cfg_data[14:0];
        REG_SETTLE:   cfg_nxt.settle_us  = cfg_data;
        REG_TAG_WIN:  cfg_nxt.tag_win_us = cfg_data;
        REG_DECIM:    cfg_nxt.decim      = cfg_data[7:0];
        REG_MIN_FRM:  cfg_nxt.min_frames = cfg_data;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.move_th    <= MOVE_TH_RST;
      cfg_r.still_th   <= STILL_TH_RST;
      cfg_r.settle_us  <= SETTLE_RST;
      cfg_r.tag_win_us <= TAG_WIN_RST;
      cfg_r.decim      <= DECIM_RST;
      cfg_r.min_frames <= MIN_FRM_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: peak tracking and frame close
  msd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .joint_speed (in_tdata[15:0]),
    .last_joint  (in_tlast),
    .elapsed_us  (in_tdata[39:16]),
    .buttons     (in_tdata[55:40]),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_in)
  );

  // frame queue
  msd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  // back: segment tracking and result beat
  msd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_empty         (q_empty),
    .q_data          (q_out),
    .q_pop           (q_pop),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .event_res       (ev),
    .capture_frame   (cap),
    .frame_count     (cnt),
    .button_mask     (mask),
    .segment_number  (segn),
    .segment_time_us (segt),
    .frame_max_speed (pk)
  );

  // result packing
  assign out_tuser = {cap, ev};
  assign out_tdata = {1'b0, pk, segt, segn, mask, cnt};

endmodule

// ===== dv/tb_motion_segment_detector.sv =====
// ----------------------------------------------------------------------------
// tb_motion_segment_detector
// Self-checking bench for the motion segment detector. A table of directed
// joint beats (idle, start, quiet-out, speed and elapsed-time clamps) runs
// first at reset settings. Several register settings follow, extremes among
// them, each fed with bursts of fast and quiet frames under varying idling.
// Each frame result is compared with the in-bench model or a fixed table entry.
// ----------------------------------------------------------------------------
module tb_motion_segment_detector;
  timeunit 1ns;
  timeprecision 1ps;
  import msd_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int STUCK_LIMIT  = 4000;
  localparam int LONG_HOLD    = 300;
  localparam int NUM_PHASES   = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  localparam int KIND_QUIET  = 0;
  localparam int KIND_ACTIVE = 1;
  localparam int KIND_NOISE  = 2;

  typedef struct packed {
    event_t      ev;
    logic        capture;
    logic [23:0] frames;
    logic [15:0] tags;
    logic [15:0] segments;
    logic [31:0] seg_us;
    logic [14:0] peak;
  } frame_result_t;

  typedef struct packed {
    logic signed [15:0] speed;
    logic               last;
    logic [23:0]        elapsed;
    logic [15:0]        buttons;
    logic               fixed;
    frame_result_t      want;
  } joint_row_t;

  logic                  clk;
  logic                  rst_n;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tlast;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  motion_segment_detector uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // detector model: settings and segment state
  cfg_t        mdl_cfg;
  logic        seg_active;
  logic [14:0] frame_peak;
  logic [23:0] quiet_us;
  logic [31:0] seg_us;
  logic [23:0] tag_us;
  logic [15:0] tag_bits;
  logic [7:0]  decim_cnt;
  logic [23:0] cap_frames;
  logic [15:0] saved_cnt;

  frame_result_t expected_q[$];
  joint_row_t    dir_rows[$];

  int send_idle_pct;
  int recv_stall_pct;
  bit hold_request;
  int beats_sent;
  int results_seen;
  int captures_seen;
  int holds_done;
  int settings_used;
  int err_count;
  int shown_errs;
  int stuck_cycles;
  int ev_count[8];

  // frame shaping: alternating bursts of motion and quiet
  bit burst_active;
  int burst_left;
  int peak_cap;

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [23:0] sat_add24(logic [23:0] a, logic [23:0] b);
    logic [24:0] s;
    s = a + b;
    return s[24] ? 24'hFFFFFF : s[23:0];
  endfunction

  // one joint beat through the model; a last joint yields the frame result
  task automatic predict_joint(input logic signed [15:0] speed, input logic last,
                               input logic [23:0] elapsed, input logic [15:0] buttons,
                               output bit has_res, output frame_result_t r);
    int          mag;
    logic [14:0] pk;
    logic [23:0] dt;
    logic [32:0] sum;
    has_res = 1'b0;
    r = '0;
    mag = (speed < 0) ? -int'(speed) : int'(speed);
    if (mag > 32767) mag = 32767;
    if (mag > frame_peak) frame_peak = mag[14:0];
    if (!last) return;
    has_res = 1'b1;
    pk = frame_peak;
    frame_peak = '0;
    dt = (elapsed == 0 || elapsed > DT_MAX_US) ? 24'(DT_DEFAULT_US) : elapsed;
    r.ev = EV_IDLE;
    if (!seg_active) begin
      if (pk > mdl_cfg.move_th) begin
        seg_active = 1'b1;
        decim_cnt  = '0;
        tag_bits   = '0;
        tag_us     = '0;
        seg_us     = '0;
        quiet_us   = '0;
        cap_frames = '0;
        r.ev = EV_STARTED;
      end
      r.frames = cap_frames;
    end else begin
      r.ev = EV_RECORDING;
      sum = seg_us + dt;
      seg_us = sum[32] ? 32'hFFFFFFFF : sum[31:0];
      // buttons only count inside the tag window
      if (tag_us < mdl_cfg.tag_win_us) begin
        tag_bits = tag_bits | buttons;
        tag_us = sat_add24(tag_us, dt);
      end
      if (decim_cnt < 8'hFF) decim_cnt = decim_cnt + 8'd1;
      if (decim_cnt >= mdl_cfg.decim) begin
        decim_cnt = '0;
        cap_frames = sat_add24(cap_frames, 24'd1);
        r.capture = 1'b1;
      end
      r.frames = cap_frames;
      // quiet time closes the segment
      if (pk < mdl_cfg.still_th) begin
        quiet_us = sat_add24(quiet_us, dt);
        if (quiet_us >= mdl_cfg.settle_us) begin
          seg_active = 1'b0;
          quiet_us = '0;
          if (cap_frames == 0) begin
            r.ev = EV_EMPTY;
          end else if (cap_frames < mdl_cfg.min_frames) begin
            r.ev = EV_TOO_SHORT;
          end else begin
            if (saved_cnt != 16'hFFFF) saved_cnt = saved_cnt + 16'd1;
            r.ev = EV_SAVED;
          end
          cap_frames = '0;
        end
      end else begin
        quiet_us = '0;
      end
    end
    r.tags     = tag_bits;
    r.segments = saved_cnt;
    r.seg_us   = seg_us;
    r.peak     = pk;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
      default: begin send_idle_pct = 30; recv_stall_pct = 30; end
    endcase
  endtask

  // offer one joint beat, hold it until taken, then run it through the model
  task automatic send_joint(input logic signed [15:0] speed, input logic last,
                            input logic [23:0] elapsed, input logic [15:0] buttons,
                            output bit has_res, output frame_result_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {buttons, elapsed, speed};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    beats_sent++;
    predict_joint(speed, last, elapsed, buttons, has_res, r);
  endtask

  // pause the sender until every frame result is back and the pipe is empty
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // all registers, with junk above the narrow registers' widths, plus the unused indexes
  task automatic program_regs(input cfg_t c);
    write_reg(REG_MOVE_TH,  {9'($urandom), c.move_th});
    write_reg(REG_STILL_TH, {9'($urandom), c.still_th});
    write_reg(REG_SETTLE,   c.settle_us);
    write_reg(REG_TAG_WIN,  c.tag_win_us);
    write_reg(REG_DECIM,    {16'($urandom), c.decim});
    write_reg(REG_MIN_FRM,  c.min_frames);
    write_reg(REG_SPARE_A,  24'($urandom));
    write_reg(REG_SPARE_B,  24'($urandom));
    cfg_valid <= 1'b0;
    mdl_cfg = c;
    settings_used++;
  endtask

  // one random frame of 1..max_joints beats, shaped by the current burst
  task automatic send_random_frame(input int max_joints);
    int                 nj;
    int                 pk;
    int                 kind;
    int                 mag;
    int                 lo;
    int                 pick;
    logic signed [15:0] sp;
    logic [23:0]        el;
    bit                 got;
    frame_result_t      r;
    if (burst_left == 0) begin
      burst_active = !burst_active;
      burst_left = burst_active ? $urandom_range(25, 1) : $urandom_range(12, 1);
    end
    burst_left--;
    if ($urandom_range(99) < 8) kind = KIND_NOISE;
    else kind = burst_active ? KIND_ACTIVE : KIND_QUIET;
    nj = $urandom_range(max_joints, 1);
    pk = $urandom_range(nj - 1, 0);
    for (int j = 0; j < nj; j++) begin
      if (kind == KIND_NOISE) begin
        sp = 16'($urandom);
        if (peak_cap < 32767 && (sp == 16'sh8000 || sp == 16'sd32767 || sp == -16'sd32767))
          sp = '0;
      end else if (kind == KIND_ACTIVE && j == pk) begin
        if (mdl_cfg.move_th >= peak_cap) begin
          mag = peak_cap;
        end else begin
          lo = mdl_cfg.move_th + 1;
          if ($urandom_range(1) == 1)
            mag = $urandom_range((lo + 300 > peak_cap) ? peak_cap : lo + 300, lo);
          else
            mag = $urandom_range(peak_cap, lo);
        end
        sp = $urandom_range(1) ? 16'(-mag) : 16'(mag);
        if (peak_cap == 32767 && $urandom_range(99) < 3) sp = 16'sh8000;
      end else begin
        mag = (mdl_cfg.still_th == 0) ? 0 : $urandom_range(mdl_cfg.still_th - 1, 0);
        sp = $urandom_range(1) ? 16'(-mag) : 16'(mag);
      end
      // elapsed time: mostly plausible, with unknown and wild values mixed in
      pick = $urandom_range(99);
      if (pick < 8)       el = '0;
      else if (pick < 16) el = 24'($urandom_range(24'hFFFFFF, 100001));
      else if (pick < 20) el = $urandom_range(1) ? 24'd100000 : 24'd100001;
      else if (pick < 55) el = 24'($urandom_range(100000, 60000));
      else                el = 24'($urandom_range(100000, 1));
      send_joint(sp, (j == nj - 1), el, 16'($urandom), got, r);
      if (got) expected_q.insert(expected_q.size(), r);
    end
  endtask

  // result side: random stalls, plus one long hold on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_done++;
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    frame_result_t got;
    frame_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.ev       = event_t'(out_tuser[2:0]);
      got.capture  = out_tuser[3];
      got.frames   = out_tdata[23:0];
      got.tags     = out_tdata[39:24];
      got.segments = out_tdata[55:40];
      got.seg_us   = out_tdata[87:56];
      got.peak     = out_tdata[102:88];
      results_seen++;
      ev_count[got.ev]++;
      if (got.capture) captures_seen++;
      if (expected_q.size() == 0) begin
        err_count++;
        if (shown_errs < 10) begin
          shown_errs++;
          $display("ERROR: frame result %0d with none pending (event %0d)",
                   results_seen, got.ev);
        end
      end else begin
        want = expected_q.pop_front();
        if (got.ev !== want.ev || got.capture !== want.capture ||
            got.frames !== want.frames || got.tags !== want.tags ||
            got.segments !== want.segments || got.seg_us !== want.seg_us ||
            got.peak !== want.peak) begin
          err_count++;
          if (shown_errs < 10) begin
            shown_errs++;
            $display("ERROR: frame %0d exp ev %0d cap %0d cnt %0d tag %h seg %0d t %0d pk %0d",
                     results_seen, want.ev, want.capture, want.frames, want.tags,
                     want.segments, want.seg_us, want.peak);
            $display("       got ev %0d cap %0d cnt %0d tag %h seg %0d t %0d pk %0d",
                     got.ev, got.capture, got.frames, got.tags, got.segments,
                     got.seg_us, got.peak);
          end
        end
      end
    end
  end

  // watchdog: no beat moving on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles, %0d results pending",
               STUCK_LIMIT, expected_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // stimulus
  initial begin
    cfg_t          pc;
    joint_row_t    row;
    frame_result_t r;
    bit            got;
    int            n_items;
    int            max_joints;
    int            start;
    bit            hold_done;
    bit            pause_done;
    int            mv;

    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_request = 1'b0;
    beats_sent = 0;
    results_seen = 0;
    captures_seen = 0;
    holds_done = 0;
    settings_used = 1;
    err_count = 0;
    shown_errs = 0;
    stuck_cycles = 0;
    foreach (ev_count[i]) ev_count[i] = 0;
    burst_active = 1'b0;
    burst_left = 0;
    peak_cap = 32767;
    set_idling(3);

    // model at reset
    mdl_cfg = '{MOVE_TH_RST, STILL_TH_RST, SETTLE_RST, TAG_WIN_RST, DECIM_RST, MIN_FRM_RST};
    seg_active = 1'b0;
    frame_peak = '0;
    quiet_us = '0;
    seg_us = '0;
    tag_us = '0;
    tag_bits = '0;
    decim_cnt = '0;
    cap_frames = '0;
    saved_cnt = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed beats at reset settings: threshold edges, speed and time clamps,
    // start frames and segments that settle with nothing captured
    dir_rows.insert(dir_rows.size(), '{16'sd0, 1'b1, 24'd0, 16'h0000, 1'b1,
                         '{EV_IDLE, 1'b0, 24'd0, 16'd0, 16'd0, 32'd0, 15'd0}});
    dir_rows.insert(dir_rows.size(), '{16'sd38, 1'b1, 24'd1, 16'hFFFF, 1'b1,
                         '{EV_IDLE, 1'b0, 24'd0, 16'd0, 16'd0, 32'd0, 15'd38}});
    dir_rows.insert(dir_rows.size(), '{16'sd12345, 1'b0, 24'hFFFFFF, 16'h0000, 1'b0, '0});
    dir_rows.insert(dir_rows.size(), '{16'sh8000, 1'b1, 24'hFFFFFF, 16'hFFFF, 1'b1,
                         '{EV_STARTED, 1'b0, 24'd0, 16'd0, 16'd0, 32'd0, 15'h7FFF}});
    dir_rows.insert(dir_rows.size(), '{16'sd13, 1'b1, 24'd100000, 16'h0001, 1'b0, '0});
    dir_rows.insert(dir_rows.size(), '{-16'sd13, 1'b0, 24'd0, 16'h0000, 1'b0, '0});
    dir_rows.insert(dir_rows.size(), '{16'sd5, 1'b1, 24'd100001, 16'h8000, 1'b0, '0});
    dir_rows.insert(dir_rows.size(), '{16'sd12, 1'b1, 24'd100000, 16'h0002, 1'b0, '0});
    dir_rows.insert(dir_rows.size(), '{-16'sd12, 1'b1, 24'd100000, 16'h0000, 1'b0, '0});
    dir_rows.insert(dir_rows.size(), '{16'sd0, 1'b1, 24'd100000, 16'h0000, 1'b0, '0});
    dir_rows.insert(dir_rows.size(), '{16'sd0, 1'b1, 24'd100000, 16'h00F0, 1'b0, '0});
    dir_rows.insert(dir_rows.size(), '{16'sd1, 1'b1, 24'd100000, 16'h0000, 1'b0, '0});
    dir_rows.insert(dir_rows.size(), '{-16'sd1, 1'b1, 24'd100000, 16'h0000, 1'b0, '0});
    dir_rows.insert(dir_rows.size(), '{-16'sd39, 1'b1, 24'd500, 16'h0000, 1'b1,
                         '{EV_STARTED, 1'b0, 24'd0, 16'd0, 16'd0, 32'd0, 15'd39}});
    dir_rows.insert(dir_rows.size(), '{16'sd32767, 1'b0, 24'd0, 16'h0000, 1'b0, '0});
    dir_rows.insert(dir_rows.size(), '{16'sd0, 1'b1, 24'd7, 16'h5A5A, 1'b0, '0});
    repeat (6)
      dir_rows.insert(dir_rows.size(), '{-16'sd5, 1'b1, 24'd100000, 16'hA5A5, 1'b0, '0});

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_joint(row.speed, row.last, row.elapsed, row.buttons, got, r);
      if (got) expected_q.insert(expected_q.size(), row.fixed ? row.want : r);
    end
    wait_drained();

    // random phases, each with its own register setting and idling
    for (int p = 0; p < NUM_PHASES; p++) begin
      max_joints = 6;
      peak_cap = 32767;
      case (p)
        0: begin
          pc = '{15'd38, 15'd13, 24'd3000, 24'd5000, 8'd1, 24'd3};
          n_items = 260;
        end
        1: begin
          pc = '{15'd0, 15'd0, 24'd0, 24'd0, 8'd0, 24'd0};
          n_items = 150;
        end
        2: begin
          pc = '{15'h7FFF, 15'h7FFF, 24'hFFFFFF, 24'hFFFFFF, 8'hFF, 24'hFFFFFF};
          n_items = 80;
        end
        3: begin
          // long quiet run: quiet time and tag time saturate, decimation at top
          pc = '{15'd100, 15'h7FFF, 24'hFFFFFF, 24'hFFFFFF, 8'hFF, 24'hFFFFFF};
          n_items = 520;
          max_joints = 2;
          peak_cap = 32766;
        end
        default: begin
          mv = $urandom_range(400, 0);
          pc.move_th    = 15'(mv);
          pc.still_th   = 15'($urandom_range(mv, 0));
          pc.settle_us  = 24'($urandom_range(400000, 0));
          pc.tag_win_us = 24'($urandom_range(400000, 0));
          pc.decim      = ($urandom_range(7) == 0) ? 8'd0 : 8'($urandom_range(8, 1));
          pc.min_frames = 24'($urandom_range(6, 0));
          n_items = 200;
        end
      endcase
      program_regs(pc);
      set_idling(p % 4);
      burst_left = 0;
      hold_done = 1'b0;
      pause_done = 1'b0;
      start = beats_sent;
      while (beats_sent - start < n_items) begin
        // receiver holds off while the sender keeps offering frames
        if (p == 0 && !hold_done && beats_sent - start >= 100) begin
          hold_request = 1'b1;
          hold_done = 1'b1;
        end
        // sender stops mid-phase until every result is back
        if (p == 4 && !pause_done && beats_sent - start >= 120) begin
          wait_drained();
          pause_done = 1'b1;
        end
        send_random_frame(max_joints);
      end
      wait_drained();
    end

    if (expected_q.size() != 0) err_count++;
    $display("run covered %0d joint beats, %0d frame results, %0d register settings",
             beats_sent, results_seen, settings_used);
    $display("events idle %0d started %0d recording %0d saved %0d short %0d empty %0d,",
             ev_count[EV_IDLE], ev_count[EV_STARTED], ev_count[EV_RECORDING],
             ev_count[EV_SAVED], ev_count[EV_TOO_SHORT], ev_count[EV_EMPTY]);
    $display("  %0d captures, %0d long receiver holds", captures_seen, holds_done);
    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
